// ===== hdl/lcg48_random_generator_top_assert.svh =====
// ---------------------------------------------------------------------------
// LCG48 assertion macros
// Shared property forms for the stream checks of the 48-bit LCG generator.
// ---------------------------------------------------------------------------
`ifndef LCG48_RANDOM_GENERATOR_TOP_ASSERT_SVH
`define LCG48_RANDOM_GENERATOR_TOP_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define LCG48_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lcg48 check failed");

// Check a condition in the cycle after its trigger.
`define LCG48_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lcg48 check failed");

// Hold a stalled beat: valid stays up and its payload stays unchanged.
`define LCG48_ASSERT_HOLD(label, clk, rstn, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!rstn) \
        (vld) && !(rdy) |=> (vld) && $stable(sig)) \
        else $error("lcg48 check failed");

`endif

// ===== hdl/lcg48_pkg.sv =====
// ---------------------------------------------------------------------------
// LCG48 package
// Constants, command codes and helpers for the 48-bit LCG generator.
// ---------------------------------------------------------------------------
package lcg48_pkg;

    localparam int StateW    = 48;
    localparam int MultW     = 35;
    localparam int ChunkW    = 16;
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 64;

    localparam logic [MultW-1:0]  LCG_MULT = 35'h5DEECE66D;
    localparam logic [StateW-1:0] LCG_INC  = 48'hB;

    localparam logic [2:0] CMD_RESEED  = 3'd0;
    localparam logic [2:0] CMD_BITS    = 3'd1;
    localparam logic [2:0] CMD_BOUNDED = 3'd2;
    localparam logic [2:0] CMD_LONG    = 3'd3;
    localparam logic [2:0] CMD_DOUBLE  = 3'd4;

    // Top nb bits of the state (nb in 0..32); nb of zero gives zero.
    function automatic logic [31:0] top_bits(input logic [StateW-1:0] s,
                                             input logic [5:0] nb);
        logic [5:0]        shift;
        logic [StateW-1:0] sh;
        shift = 6'd48 - nb;
        sh    = s >> shift;
        return sh[31:0];
    endfunction

endpackage

// ===== hdl/lcg48_random_generator_top.sv =====
// ---------------------------------------------------------------------------
// LCG48 random generator
// 48-bit linear congruential generator with reseed, bit draw, bounded
// integer, long and double-mantissa commands; one result beat per command.
// ---------------------------------------------------------------------------
// One command at a time. Each state advance uses a 16x35 multiplier three
// times. Reseed, bad bound and unused commands go straight to the output
// step; draw bits takes one state advance, a power-of-two bound one advance
// and a product step, long and double mantissa two. Other bounds run
// a one-bit-per-cycle remainder unit and a check after an advance, repeated
// on each rejected draw. s_tready is high only between commands; a finished
// result waits in the output register while the next command is taken, and
// the last cycle of a command repeats until that register is free.
module lcg48_random_generator_top import lcg48_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // seed_value[63:0], bit_count[69:64], bound[101:70], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[2:0]
    input  logic [2:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // value[63:0]
    output logic [M_TDATA_W-1:0] m_tdata,
    // error[0]
    output logic [0:0]           m_tuser
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_POST  = 3'd2;
    localparam logic [2:0] ST_PROD  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_CHECK = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [5:0]        nbits_reg, nbits_next;
    logic [30:0]       bound_reg, bound_next;
    logic              pow2_reg, pow2_next;
    logic              second_reg, second_next;
    logic [1:0]        chunk_reg, chunk_next;
    logic [StateW-1:0] lcg_reg, lcg_next;
    logic [StateW-1:0] acc_reg, acc_next;
    logic [31:0]       hi_reg, hi_next;
    logic [30:0]       draw_reg, draw_next;
    logic [30:0]       rem_reg, rem_next;
    logic [30:0]       dvd_reg, dvd_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [63:0]       res_value_reg, res_value_next;
    logic              res_err_reg, res_err_next;
    logic              m_valid_reg, m_valid_next;
    logic [63:0]       m_data_reg, m_data_next;
    logic              m_err_reg, m_err_next;

    logic [63:0]       in_seed;
    logic [5:0]        in_nbits;
    logic [31:0]       in_bound;
    logic              in_accept;
    logic [ChunkW-1:0] mul_chunk;
    logic [ChunkW+MultW-1:0] pp;
    logic [StateW-1:0] pp_sh;
    logic [31:0]       d32;
    logic [31:0]       trial;
    logic [61:0]       prod;
    logic [31:0]       chk;

    assign in_seed   = s_tdata[63:0];
    assign in_nbits  = s_tdata[69:64];
    assign in_bound  = s_tdata[101:70];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_err_reg;

    always_comb begin
        unique case (chunk_reg)
            2'd0:    mul_chunk = lcg_reg[15:0];
            2'd1:    mul_chunk = lcg_reg[31:16];
            default: mul_chunk = lcg_reg[47:32];
        endcase
    end

    assign pp = {{MultW{1'b0}}, mul_chunk} * {{ChunkW{1'b0}}, LCG_MULT};

    always_comb begin
        unique case (chunk_reg)
            2'd0:    pp_sh = pp[47:0];
            2'd1:    pp_sh = {pp[31:0], 16'b0};
            default: pp_sh = {pp[15:0], 32'b0};
        endcase
    end

    assign d32   = top_bits(lcg_reg, nbits_reg);
    assign trial = {rem_reg, dvd_reg[30]};
    assign prod  = {31'b0, bound_reg} * {31'b0, draw_reg};
    assign chk   = {1'b0, draw_reg} - {1'b0, rem_reg} + {1'b0, bound_reg} - 32'd1;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        nbits_next     = nbits_reg;
        bound_next     = bound_reg;
        pow2_next      = pow2_reg;
        second_next    = second_reg;
        chunk_next     = chunk_reg;
        lcg_next       = lcg_reg;
        acc_next       = acc_reg;
        hi_next        = hi_reg;
        draw_next      = draw_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        cnt_next       = cnt_reg;
        res_value_next = res_value_reg;
        res_err_next   = res_err_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_err_next     = m_err_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    cmd_next       = s_tuser;
                    res_value_next = '0;
                    res_err_next   = 1'b0;
                    second_next    = 1'b0;
                    acc_next       = LCG_INC;
                    chunk_next     = 2'd0;
                    state_next     = ST_MUL;
                    unique case (s_tuser)
                        CMD_RESEED: begin
                            lcg_next   = in_seed[47:0] ^ {13'b0, LCG_MULT};
                            state_next = ST_OUT;
                        end
                        CMD_BITS: begin
                            nbits_next = (in_nbits > 6'd32) ? 6'd32 : in_nbits;
                        end
                        CMD_BOUNDED: begin
                            nbits_next = 6'd31;
                            bound_next = in_bound[30:0];
                            pow2_next  = ((in_bound & (~in_bound + 32'd1)) == in_bound);
                            if (in_bound == 32'd0 || in_bound[31]) begin
                                res_err_next = 1'b1;
                                state_next   = ST_OUT;
                            end
                        end
                        CMD_LONG: begin
                            nbits_next = 6'd32;
                        end
                        CMD_DOUBLE: begin
                            nbits_next = 6'd26;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                acc_next = acc_reg + pp_sh;
                if (chunk_reg == 2'd2) begin
                    lcg_next   = acc_reg + pp_sh;
                    state_next = ST_POST;
                end else begin
                    chunk_next = chunk_reg + 2'd1;
                end
            end
            ST_POST: begin
                acc_next   = LCG_INC;
                chunk_next = 2'd0;
                unique case (cmd_reg)
                    CMD_BITS: begin
                        res_value_next = (nbits_reg == 6'd32) ? {{32{d32[31]}}, d32}
                                                              : {32'b0, d32};
                        state_next     = ST_OUT;
                    end
                    CMD_LONG: begin
                        if (!second_reg) begin
                            hi_next     = d32;
                            second_next = 1'b1;
                            state_next  = ST_MUL;
                        end else begin
                            res_value_next = {hi_reg, 32'b0} + {{32{d32[31]}}, d32};
                            state_next     = ST_OUT;
                        end
                    end
                    CMD_DOUBLE: begin
                        if (!second_reg) begin
                            hi_next     = d32;
                            second_next = 1'b1;
                            nbits_next  = 6'd27;
                            state_next  = ST_MUL;
                        end else begin
                            res_value_next = ({32'b0, hi_reg} << 27) + {32'b0, d32};
                            state_next     = ST_OUT;
                        end
                    end
                    CMD_BOUNDED: begin
                        draw_next = d32[30:0];
                        dvd_next  = d32[30:0];
                        rem_next  = '0;
                        cnt_next  = 5'd30;
                        state_next = pow2_reg ? ST_PROD : ST_DIV;
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_PROD: begin
                res_value_next = {33'b0, prod[61:31]};
                state_next     = ST_OUT;
            end
            ST_DIV: begin
                if (trial >= {1'b0, bound_reg}) begin
                    rem_next = 31'(trial - {1'b0, bound_reg});
                end else begin
                    rem_next = trial[30:0];
                end
                dvd_next = {dvd_reg[29:0], 1'b0};
                if (cnt_reg == 5'd0) begin
                    state_next = ST_CHECK;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_CHECK: begin
                if (chk[31]) begin
                    state_next = ST_MUL;
                end else begin
                    res_value_next = {33'b0, rem_reg};
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_value_reg;
                    m_err_next   = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            lcg_reg     <= {13'b0, LCG_MULT};
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            lcg_reg     <= lcg_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        nbits_reg     <= nbits_next;
        bound_reg     <= bound_next;
        pow2_reg      <= pow2_next;
        second_reg    <= second_next;
        chunk_reg     <= chunk_next;
        acc_reg       <= acc_next;
        hi_reg        <= hi_next;
        draw_reg      <= draw_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        cnt_reg       <= cnt_next;
        res_value_reg <= res_value_next;
        res_err_reg   <= res_err_next;
        m_data_reg    <= m_data_next;
        m_err_reg     <= m_err_next;
    end

endmodule

// ===== hdl/lcg48_checker.sv =====
// ---------------------------------------------------------------------------
// LCG48 stream checker
// Port-level checks for the 48-bit LCG generator, bound to its top level.
// ---------------------------------------------------------------------------
`include "lcg48_random_generator_top_assert.svh"

module lcg48_checker import lcg48_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [2:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser
);

    `LCG48_ASSERT_HOLD(a_out_hold, aclk, aresetn, m_tvalid, m_tready, {m_tdata, m_tuser})
    `LCG48_ASSERT_HOLD(a_in_hold, aclk, aresetn, s_tvalid, s_tready, {s_tdata, s_tuser})
    `LCG48_ASSERT_SAME(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)
    `LCG48_ASSERT_NEXT(a_one_cmd, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind lcg48_random_generator_top lcg48_checker u_lcg48_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
